// ===== design/pcs_pkg.sv =====
// Shared types, constants and tables of the point colormap shader.
package pcs_pkg;

   // Field and datapath widths
   localparam int VAL_W   = 32;
   localparam int DIFF_W  = VAL_W + 1;
   localparam int COLOR_W = 32;
   localparam int FRAC_W  = 16;
   localparam int T_W     = FRAC_W + 1;
   localparam int SEG_SHIFT = 14;
   localparam int U_W     = SEG_SHIFT + 1;
   localparam int STOP_W  = 7;
   localparam int SEG_W   = 3;
   localparam int NUM_W   = 21;
   localparam int ACC_W   = NUM_W + 3;
   localparam int MUL_W   = NUM_W + 8;
   localparam int Q_W     = 15;
   localparam int PROD_W  = 27;
   localparam int CH_W    = 8;

   // Channel scaling: ch = floor(num * 255 / (100 * 2^14))
   localparam int CH_SCALE    = 255;
   localparam int RECIP_MUL   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int CH_MAX      = 244;
   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Gradient stops in hundredths, channels r, g, b
   localparam int NUM_STOPS = 5;
   localparam int NUM_CHAN  = 3;
   localparam logic [STOP_W-1:0] GRAD_STOP [NUM_STOPS][NUM_CHAN] = '{
      '{7'd15, 7'd35, 7'd95},
      '{7'd10, 7'd85, 7'd95},
      '{7'd20, 7'd82, 7'd28},
      '{7'd96, 7'd86, 7'd22},
      '{7'd95, 7'd26, 7'd16}
   };
   localparam logic [SEG_W-1:0] SEG_LAST = 3'd3;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HAS_INT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HAS_RGB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_MIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_MAX       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HGT_MIN       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HGT_MAX       = 3'd6;

   localparam logic signed [VAL_W-1:0] BOUND_MIN_RESET = 32'sd0;
   localparam logic signed [VAL_W-1:0] BOUND_MAX_RESET = 32'sd65536;

   typedef enum logic [1:0] {
      MODE_FLAT      = 2'd0,
      MODE_INTENSITY = 2'd1,
      MODE_HEIGHT    = 2'd2,
      MODE_RGB       = 2'd3
   } mode_type;

   // How the normalized position t is formed
   typedef enum logic [1:0] {
      TSEL_DIV,
      TSEL_ZERO,
      TSEL_ONE,
      TSEL_HALF
   } tsel_type;

   // Color that skips the gradient, and whether it does
   typedef struct packed {
      logic                bypass;
      logic [COLOR_W-1:0]  color;
   } pcs_side_type;

   // Divider operands with the special-case selection
   typedef struct packed {
      tsel_type            tsel;
      logic [VAL_W-1:0]    num;
      logic [VAL_W-1:0]    den;
   } pcs_frac_type;

   // Normalized position before the gradient
   typedef struct packed {
      tsel_type            tsel;
      logic [FRAC_W-1:0]   quo;
   } pcs_t_type;

   function automatic logic [COLOR_W-1:0] mode_default(mode_type mode);
      logic [COLOR_W-1:0] color;
      unique case (mode)
         MODE_FLAT:      color = 32'hFFFFCE84;
         MODE_INTENSITY: color = 32'hFF5CD6FF;
         MODE_HEIGHT:    color = 32'hFF82E4AA;
         MODE_RGB:       color = 32'hFFFFFFFF;
         default:        color = 32'hFFFFFFFF;
      endcase
      return color;
   endfunction

endpackage

// ===== design/pcs_norm.sv =====
// Front end: mode selection, bound differences and special-case classification.
module pcs_norm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  pcs_pkg::mode_type                 shade_mode,
   input  logic                              frame_has_intensity,
   input  logic                              frame_has_rgb,
   input  logic signed [pcs_pkg::VAL_W-1:0]  intensity_min,
   input  logic signed [pcs_pkg::VAL_W-1:0]  intensity_max,
   input  logic signed [pcs_pkg::VAL_W-1:0]  height_min,
   input  logic signed [pcs_pkg::VAL_W-1:0]  height_max,
   input  logic signed [pcs_pkg::VAL_W-1:0]  point_height,
   input  logic signed [pcs_pkg::VAL_W-1:0]  point_intensity,
   input  logic                              point_has_intensity,
   input  logic                              point_has_rgb,
   input  logic [pcs_pkg::COLOR_W-1:0]       point_color,
   output logic                              out_valid,
   input  logic                              out_ready,
   output pcs_pkg::pcs_frac_type             out_frac,
   output pcs_pkg::pcs_side_type             out_side
);
   import pcs_pkg::*;

   logic                      s1_v_ff;
   logic                      s1_en;
   pcs_side_type              s1_side_ff, s1_side_in;
   logic signed [DIFF_W-1:0]  s1_diff_ff, s1_diff_in;
   logic signed [DIFF_W-1:0]  s1_offs_ff, s1_offs_in;

   logic                      s2_v_ff;
   logic                      s2_en;
   pcs_side_type              s2_side_ff;
   pcs_frac_type              s2_frac_ff, s2_frac_in;

   // Advance a stage when it is empty or the next one advances
   assign s2_en    = !s2_v_ff || out_ready;
   assign s1_en    = !s1_v_ff || s2_en;
   assign in_ready = s1_en;

   // Pick the value and bounds, form differences at full width
   always_comb begin
      logic                      use_int;
      logic                      use_hgt;
      logic                      rgb_pass;
      logic signed [VAL_W-1:0]   v_sel;
      logic signed [VAL_W-1:0]   lo_sel;
      logic signed [VAL_W-1:0]   hi_sel;
      use_int  = (shade_mode == MODE_INTENSITY) && frame_has_intensity && point_has_intensity;
      use_hgt  = (shade_mode == MODE_HEIGHT);
      rgb_pass = (shade_mode == MODE_RGB) && frame_has_rgb && point_has_rgb;
      v_sel    = use_int ? point_intensity : point_height;
      lo_sel   = use_int ? intensity_min   : height_min;
      hi_sel   = use_int ? intensity_max   : height_max;
      s1_diff_in = DIFF_W'(hi_sel) - DIFF_W'(lo_sel);
      s1_offs_in = DIFF_W'(v_sel) - DIFF_W'(lo_sel);
      s1_side_in.bypass = !(use_int || use_hgt);
      s1_side_in.color  = rgb_pass ? point_color : mode_default(shade_mode);
   end

   // Classify: empty range, below, above, or a real quotient
   always_comb begin
      logic d_pos;
      logic n_pos;
      d_pos = !s1_diff_ff[DIFF_W-1] && (s1_diff_ff != '0);
      n_pos = !s1_offs_ff[DIFF_W-1] && (s1_offs_ff != '0);
      if (!d_pos) begin
         s2_frac_in.tsel = TSEL_HALF;
      end else if (!n_pos) begin
         s2_frac_in.tsel = TSEL_ZERO;
      end else if (s1_offs_ff >= s1_diff_ff) begin
         s2_frac_in.tsel = TSEL_ONE;
      end else begin
         s2_frac_in.tsel = TSEL_DIV;
      end
      s2_frac_in.num = s1_offs_ff[VAL_W-1:0];
      s2_frac_in.den = s1_diff_ff[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= in_valid;
         if (s2_en) s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_side_ff <= s1_side_in;
         s1_diff_ff <= s1_diff_in;
         s1_offs_ff <= s1_offs_in;
      end
      if (s2_en) begin
         s2_side_ff <= s1_side_ff;
         s2_frac_ff <= s2_frac_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_frac  = s2_frac_ff;
   assign out_side  = s2_side_ff;

`ifndef SYNTHESIS
   // A request sent to the divider has 0 < num < den
   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && (s2_frac_ff.tsel == TSEL_DIV)
      |-> (s2_frac_ff.num != '0) && (s2_frac_ff.num < s2_frac_ff.den))
      else $error("divider operands out of range");
`endif

endmodule

// ===== design/pcs_div.sv =====
// Pipelined restoring divider: one quotient bit of num * 2^16 / den per stage.
module pcs_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pcs_pkg::pcs_frac_type  in_frac,
   input  pcs_pkg::pcs_side_type  in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pcs_pkg::pcs_t_type     out_t,
   output pcs_pkg::pcs_side_type  out_side
);
   import pcs_pkg::*;

   localparam int STEPS = FRAC_W;

   logic [STEPS-1:0]   v_ff;
   logic [STEPS:0]     en;
   tsel_type           tsel_ff [STEPS];
   tsel_type           tsel_in [STEPS];
   logic [VAL_W-1:0]   rem_ff  [STEPS];
   logic [VAL_W-1:0]   rem_in  [STEPS];
   logic [VAL_W-1:0]   den_ff  [STEPS];
   logic [VAL_W-1:0]   den_in  [STEPS];
   logic [FRAC_W-1:0]  quo_ff  [STEPS];
   logic [FRAC_W-1:0]  quo_in  [STEPS];
   pcs_side_type       side_ff [STEPS];
   pcs_side_type       side_in [STEPS];
   logic [STEPS-1:0]   v_in;

   // Ready chain: a stage moves when empty or when the next stage moves
   always_comb begin
      en[STEPS] = out_ready;
      for (int k = STEPS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // One shift, compare and subtract per stage
   always_comb begin
      logic [VAL_W-1:0]   src_rem;
      logic [FRAC_W-1:0]  src_quo;
      logic [VAL_W:0]     shifted;
      logic [VAL_W:0]     den_ext;
      logic               ge;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            v_in[k]    = in_valid;
            tsel_in[k] = in_frac.tsel;
            den_in[k]  = in_frac.den;
            side_in[k] = in_side;
            src_rem    = in_frac.num;
            src_quo    = '0;
         end else begin
            v_in[k]    = v_ff[k-1];
            tsel_in[k] = tsel_ff[k-1];
            den_in[k]  = den_ff[k-1];
            side_in[k] = side_ff[k-1];
            src_rem    = rem_ff[k-1];
            src_quo    = quo_ff[k-1];
         end
         shifted   = {src_rem, 1'b0};
         den_ext   = {1'b0, den_in[k]};
         ge        = (shifted >= den_ext);
         rem_in[k] = ge ? VAL_W'(shifted - den_ext) : shifted[VAL_W-1:0];
         quo_in[k] = {src_quo[FRAC_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < STEPS; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         if (en[k]) begin
            tsel_ff[k] <= tsel_in[k];
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            quo_ff[k]  <= quo_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid  = v_ff[STEPS-1];
   assign out_t.tsel = tsel_ff[STEPS-1];
   assign out_t.quo  = quo_ff[STEPS-1];
   assign out_side   = side_ff[STEPS-1];

`ifndef SYNTHESIS
   // The partial remainder of a real quotient stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      v_ff[STEPS-1] && (tsel_ff[STEPS-1] == TSEL_DIV)
      |-> (rem_ff[STEPS-1] < den_ff[STEPS-1]))
      else $error("divider remainder not below divisor");
`endif

endmodule

// ===== design/pcs_grad.sv =====
// Five-stop gradient: segment lookup, interpolation and channel scaling.
module pcs_grad (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  pcs_pkg::pcs_t_type              in_t,
   input  pcs_pkg::pcs_side_type           in_side,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [pcs_pkg::COLOR_W-1:0]     out_color
);
   import pcs_pkg::*;

   logic                 g1_v_ff, g2_v_ff, g3_v_ff, o_v_ff;
   logic                 g1_en, g2_en, g3_en, o_en;
   pcs_side_type         g1_side_ff, g2_side_ff, g3_side_ff;
   logic [NUM_W-1:0]     g1_num_ff  [NUM_CHAN];
   logic [NUM_W-1:0]     g1_num_in  [NUM_CHAN];
   logic [Q_W-1:0]       g2_q_ff    [NUM_CHAN];
   logic [Q_W-1:0]       g2_q_in    [NUM_CHAN];
   logic [PROD_W-1:0]    g3_prod_ff [NUM_CHAN];
   logic [PROD_W-1:0]    g3_prod_in [NUM_CHAN];
   logic [COLOR_W-1:0]   o_color_ff, o_color_in;

   // Ready chain through the output register
   assign o_en     = !o_v_ff  || out_ready;
   assign g3_en    = !g3_v_ff || o_en;
   assign g2_en    = !g2_v_ff || g3_en;
   assign g1_en    = !g1_v_ff || g2_en;
   assign in_ready = g1_en;

   // Form t, pick the segment and interpolate between its stops
   always_comb begin
      logic [T_W-1:0]            t;
      logic [SEG_W-1:0]          seg;
      logic [U_W-1:0]            u;
      logic [STOP_W-1:0]         a;
      logic [STOP_W-1:0]         b;
      logic signed [STOP_W:0]    slope;
      logic signed [ACC_W-1:0]   acc;
      case (in_t.tsel)
         TSEL_DIV:  t = {1'b0, in_t.quo};
         TSEL_ZERO: t = '0;
         TSEL_ONE:  t = T_W'(1 << FRAC_W);
         TSEL_HALF: t = T_W'(1 << (FRAC_W - 1));
         default:   t = '0;
      endcase
      if (t[FRAC_W]) begin
         seg = SEG_LAST;
         u   = U_W'(1 << SEG_SHIFT);
      end else begin
         seg = SEG_W'(t[FRAC_W-1:SEG_SHIFT]);
         u   = {1'b0, t[SEG_SHIFT-1:0]};
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         a     = GRAD_STOP[seg][c];
         b     = GRAD_STOP[seg + SEG_W'(1)][c];
         slope = $signed({1'b0, b}) - $signed({1'b0, a});
         acc   = (ACC_W'($signed({1'b0, a})) <<< SEG_SHIFT)
               + ACC_W'(slope) * ACC_W'($signed({1'b0, u}));
         g1_num_in[c] = acc[NUM_W-1:0];
      end
   end

   // Scale by 255 and drop the segment fraction, then multiply by 1/100
   always_comb begin
      logic [MUL_W-1:0] scaled;
      for (int c = 0; c < NUM_CHAN; c++) begin
         scaled        = MUL_W'(g1_num_ff[c]) * MUL_W'(CH_SCALE);
         g2_q_in[c]    = scaled[SEG_SHIFT +: Q_W];
         g3_prod_in[c] = PROD_W'(g2_q_ff[c]) * PROD_W'(RECIP_MUL);
      end
   end

   // Assemble the packed color, or pass the bypass color
   always_comb begin
      if (g3_side_ff.bypass) begin
         o_color_in = g3_side_ff.color;
      end else begin
         o_color_in = {ALPHA_OPAQUE,
                       g3_prod_ff[2][RECIP_SHIFT +: CH_W],
                       g3_prod_ff[1][RECIP_SHIFT +: CH_W],
                       g3_prod_ff[0][RECIP_SHIFT +: CH_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_v_ff <= 1'b0;
         g2_v_ff <= 1'b0;
         g3_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (g1_en) g1_v_ff <= in_valid;
         if (g2_en) g2_v_ff <= g1_v_ff;
         if (g3_en) g3_v_ff <= g2_v_ff;
         if (o_en)  o_v_ff  <= g3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (g1_en) begin
         g1_side_ff <= in_side;
         g1_num_ff  <= g1_num_in;
      end
      if (g2_en) begin
         g2_side_ff <= g1_side_ff;
         g2_q_ff    <= g2_q_in;
      end
      if (g3_en) begin
         g3_side_ff <= g2_side_ff;
         g3_prod_ff <= g3_prod_in;
      end
      if (o_en) begin
         o_color_ff <= o_color_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_color = o_color_ff;

`ifndef SYNTHESIS
   // Interpolated channels never pass the brightest stop
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      g3_v_ff && !g3_side_ff.bypass
      |-> (g3_prod_ff[0][RECIP_SHIFT +: CH_W] <= CH_W'(CH_MAX))
       && (g3_prod_ff[1][RECIP_SHIFT +: CH_W] <= CH_W'(CH_MAX))
       && (g3_prod_ff[2][RECIP_SHIFT +: CH_W] <= CH_W'(CH_MAX)))
      else $error("gradient channel above brightest stop");
`endif

endmodule

// ===== design/point_colormap_shader_core.sv =====
// Top level of the point colormap shader: registers and the three pipeline parts.
//
// Colors one point per request and returns one packed RGBA word per request,
// in order. The pipeline takes a new point every cycle unless a stall on the
// result side holds it. Each point passes the bound-difference and range
// classification stages, the divider stages that each form one bit of the
// normalized position, and the gradient lookup, scaling and output register
// stages. Every stage holds its own valid bit, so a stall on the result side
// fills empty stages before it reaches req_tready. Registers are written
// through the csr port and apply to points accepted afterwards.
module point_colormap_shader_core (
   input  logic                               clock,
   input  logic                               reset,
   // Requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_height [31:0], point_intensity [63:32], point_color [95:64]
   input  logic [95:0]                        req_tdata,
   // point_has_intensity [0], point_has_rgb [1]
   input  logic [1:0]                         req_tuser,
   // Results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // color_out [31:0]
   output logic [pcs_pkg::COLOR_W-1:0]        rsp_tdata,
   // Register writes
   input  logic                               csr_we,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [pcs_pkg::VAL_W-1:0]          csr_wdata
);
   import pcs_pkg::*;

   mode_type                  shade_mode_ff;
   logic                      frame_has_int_ff;
   logic                      frame_has_rgb_ff;
   logic signed [VAL_W-1:0]   int_min_ff;
   logic signed [VAL_W-1:0]   int_max_ff;
   logic signed [VAL_W-1:0]   hgt_min_ff;
   logic signed [VAL_W-1:0]   hgt_max_ff;

   logic                      norm_valid, norm_ready;
   pcs_frac_type              norm_frac;
   pcs_side_type              norm_side;
   logic                      div_valid, div_ready;
   pcs_t_type                 div_t;
   pcs_side_type              div_side;

   // Hold the frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shade_mode_ff    <= MODE_FLAT;
         frame_has_int_ff <= 1'b0;
         frame_has_rgb_ff <= 1'b0;
         int_min_ff       <= BOUND_MIN_RESET;
         int_max_ff       <= BOUND_MAX_RESET;
         hgt_min_ff       <= BOUND_MIN_RESET;
         hgt_max_ff       <= BOUND_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_COLOR_MODE:    shade_mode_ff    <= mode_type'(csr_wdata[1:0]);
            CSR_FRAME_HAS_INT: frame_has_int_ff <= csr_wdata[0];
            CSR_FRAME_HAS_RGB: frame_has_rgb_ff <= csr_wdata[0];
            CSR_INT_MIN:       int_min_ff       <= $signed(csr_wdata);
            CSR_INT_MAX:       int_max_ff       <= $signed(csr_wdata);
            CSR_HGT_MIN:       hgt_min_ff       <= $signed(csr_wdata);
            CSR_HGT_MAX:       hgt_max_ff       <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   pcs_norm u_norm (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (req_tvalid),
      .in_ready            (req_tready),
      .shade_mode          (shade_mode_ff),
      .frame_has_intensity (frame_has_int_ff),
      .frame_has_rgb       (frame_has_rgb_ff),
      .intensity_min       (int_min_ff),
      .intensity_max       (int_max_ff),
      .height_min          (hgt_min_ff),
      .height_max          (hgt_max_ff),
      .point_height        ($signed(req_tdata[31:0])),
      .point_intensity     ($signed(req_tdata[63:32])),
      .point_has_intensity (req_tuser[0]),
      .point_has_rgb       (req_tuser[1]),
      .point_color         (req_tdata[95:64]),
      .out_valid           (norm_valid),
      .out_ready           (norm_ready),
      .out_frac            (norm_frac),
      .out_side            (norm_side)
   );

   pcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_frac   (norm_frac),
      .in_side   (norm_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_t     (div_t),
      .out_side  (div_side)
   );

   pcs_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_t      (div_t),
      .in_side   (div_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_color (rsp_tdata)
   );

`ifndef SYNTHESIS
   // No result comes out in the cycle after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the point colormap shader core.
`timescale 1ns / 100ps

module testbench;
   import pcs_pkg::*;

   // Point fields as they travel on the request channel
   typedef struct packed {
      logic signed [31:0] height;
      logic signed [31:0] intensity;
      logic               has_int;
      logic               has_rgb;
      logic [31:0]        color;
   } point_type;

   localparam int POS_ONE  = 65536;
   localparam int POS_HALF = 32768;
   localparam int SPAN_ONE = 16384;
   localparam longint LEVEL_SCALE = 1638400;
   localparam longint VAL_TOP     = 64'sd2147483647;
   localparam longint VAL_BOTTOM  = -64'sd2147483648;
   localparam int RANDOM_PHASES   = 16;
   localparam int PHASE_POINTS    = 115;
   localparam int CALM_PHASE      = 13;

   // Stop colors in hundredths: blue, cyan, green, yellow, red
   localparam int RAMP_LEVEL [5][3] = '{
      '{15, 35, 95},
      '{10, 85, 95},
      '{20, 82, 28},
      '{96, 86, 22},
      '{95, 26, 16}
   };

   localparam logic [31:0] FLAT_RGBA      = 32'hFFFFCE84;
   localparam logic [31:0] INTENSITY_RGBA = 32'hFF5CD6FF;
   localparam logic [31:0] HEIGHT_RGBA    = 32'hFF82E4AA;
   localparam logic [31:0] RGB_RGBA       = 32'hFFFFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   // Shadow copy of the block's registers
   mode_type           cfg_mode = MODE_FLAT;
   logic               cfg_frame_int = 1'b0;
   logic               cfg_frame_rgb = 1'b0;
   logic signed [31:0] cfg_int_min = 32'sd0;
   logic signed [31:0] cfg_int_max = 32'sd65536;
   logic signed [31:0] cfg_hgt_min = 32'sd0;
   logic signed [31:0] cfg_hgt_max = 32'sd65536;

   point_type   point_queue [$];
   logic [31:0] color_expect [$];
   point_type   cur_point;
   logic [31:0] want_color;
   int          send_gap = 0;
   int          recv_gap = 0;
   bit          calm = 1'b0;
   int          errors = 0;
   int          checked = 0;
   int          settings = 0;
   int          mode_hits [4] = '{0, 0, 0, 0};

   point_colormap_shader_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Normalized position t in Q1.16, 65536 meaning one
   function automatic logic [16:0] norm_pos(logic signed [31:0] v, logic signed [31:0] lo,
                                            logic signed [31:0] hi);
      longint d;
      longint n;
      d = longint'(hi) - longint'(lo);
      n = longint'(v) - longint'(lo);
      if (d <= 0) return 17'(POS_HALF);
      if (n <= 0) return 17'd0;
      if (n >= d) return 17'(POS_ONE);
      return 17'((n << 16) / d);
   endfunction

   // Five-stop piecewise-linear gradient, opaque alpha
   function automatic logic [31:0] ramp_color(logic [16:0] pos);
      int          seg;
      int          u;
      int          c;
      longint      level;
      logic [31:0] rgba;
      if (pos >= POS_ONE) begin
         seg = 3;
         u = SPAN_ONE;
      end else begin
         seg = int'(pos >> 14);
         u = int'(pos) - seg * SPAN_ONE;
      end
      rgba = 32'hFF000000;
      for (c = 0; c < 3; c++) begin
         level = longint'(RAMP_LEVEL[seg][c]) * SPAN_ONE
               + longint'(RAMP_LEVEL[seg+1][c] - RAMP_LEVEL[seg][c]) * u;
         rgba[8*c +: 8] = 8'((level * 255) / LEVEL_SCALE);
      end
      return rgba;
   endfunction

   // Expected color of one point under the current registers
   function automatic logic [31:0] shade_point(point_type pt);
      if (cfg_mode == MODE_RGB && cfg_frame_rgb && pt.has_rgb)
         return pt.color;
      if (cfg_mode == MODE_INTENSITY && cfg_frame_int && pt.has_int)
         return ramp_color(norm_pos(pt.intensity, cfg_int_min, cfg_int_max));
      if (cfg_mode == MODE_HEIGHT)
         return ramp_color(norm_pos(pt.height, cfg_hgt_min, cfg_hgt_max));
      case (cfg_mode)
         MODE_FLAT:      return FLAT_RGBA;
         MODE_INTENSITY: return INTENSITY_RGBA;
         MODE_HEIGHT:    return HEIGHT_RGBA;
         default:        return RGB_RGBA;
      endcase
   endfunction

   // Value around the given bounds, now and then anywhere in range
   function automatic logic signed [31:0] pick_value(logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
      longint          span;
      longint          v;
      longint unsigned r;
      span = longint'(hi) - longint'(lo);
      if (span <= 0) span = 65536;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       v = longint'(int'($urandom));
         1:       v = longint'(lo) + span * longint'($urandom_range(0, 4)) / 4;
         default: v = longint'(lo) - span / 8 + longint'(r % longint'(span + span / 4 + 1));
      endcase
      if (v > VAL_TOP) v = VAL_TOP;
      if (v < VAL_BOTTOM) v = VAL_BOTTOM;
      return v[31:0];
   endfunction

   // Bound pair: full range, equal, inverted, wild or ordinary
   task automatic pick_bounds(output logic signed [31:0] lo, output logic signed [31:0] hi);
      longint top;
      case ($urandom_range(0, 5))
         0: begin
            lo = 32'h80000000;
            hi = 32'h7FFFFFFF;
         end
         1: begin
            lo = $urandom;
            hi = lo;
         end
         2: begin
            hi = int'($urandom) >>> 8;
            lo = hi + $urandom_range(1, 1 << 20);
         end
         3: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = int'($urandom) >>> $urandom_range(4, 16);
            top = longint'(lo) + 1 + longint'($urandom >> $urandom_range(0, 31));
            if (top > VAL_TOP) top = VAL_TOP;
            hi = top[31:0];
         end
      endcase
   endtask

   // Write one register and track it in the shadow copy
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_COLOR_MODE:    cfg_mode = mode_type'(val[1:0]);
         CSR_FRAME_HAS_INT: cfg_frame_int = val[0];
         CSR_FRAME_HAS_RGB: cfg_frame_rgb = val[0];
         CSR_INT_MIN:       cfg_int_min = val;
         CSR_INT_MAX:       cfg_int_max = val;
         CSR_HGT_MIN:       cfg_hgt_min = val;
         CSR_HGT_MAX:       cfg_hgt_max = val;
         default:           ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic add_point(input logic [31:0] h, input logic [31:0] i, input logic has_int,
                            input logic has_rgb, input logic [31:0] c);
      point_type pt;
      pt.height    = h;
      pt.intensity = i;
      pt.has_int   = has_int;
      pt.has_rgb   = has_rgb;
      pt.color     = c;
      point_queue.insert(point_queue.size(), pt);
   endtask

   // Hold until every queued point is sent and every result is back
   task automatic wait_idle();
      @(negedge clock);
      while (point_queue.size() != 0 || req_tvalid || color_expect.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Request driver: predict at acceptance, then present the next point
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            color_expect.insert(color_expect.size(), shade_point(cur_point));
            mode_hits[cfg_mode]++;
         end
         if (!req_tvalid || req_tready) begin
            if (!calm && send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (point_queue.size() > 0) begin
               cur_point = point_queue.pop_front();
               req_tdata  <= {cur_point.color, cur_point.intensity, cur_point.height};
               req_tuser  <= {cur_point.has_rgb, cur_point.has_int};
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare against the oldest prediction, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (color_expect.size() == 0) begin
               $display("%0t: result with no request pending: expected none, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want_color = color_expect.pop_front();
               if (rsp_tdata !== want_color) begin
                  $display("%0t: color_out mismatch: expected %h, actual %h",
                           $time, want_color, rsp_tdata);
                  errors++;
               end
            end
         end
         if (calm) begin
            recv_gap = 0;
            rsp_tready <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 17);
         end
      end
   end

   // Stimulus
   initial begin
      point_type          pt;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic [31:0]        junk;
      int                 p;
      int                 k;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Flat mode straight out of reset, all-zero and all-one fields
      add_point(32'h0, 32'h0, 1'b0, 1'b0, 32'h0);
      add_point(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF);
      wait_idle();

      // Intensity across every stop, inside a segment, clamped and missing
      write_reg(CSR_COLOR_MODE, MODE_INTENSITY);
      write_reg(CSR_FRAME_HAS_INT, 32'd1);
      write_reg(CSR_INT_MIN, 32'd0);
      write_reg(CSR_INT_MAX, 32'd65536);
      add_point($urandom, 32'd0, 1'b1, 1'b0, $urandom);
      add_point($urandom, 32'd16384, 1'b1, 1'b0, $urandom);
      add_point($urandom, 32'd32768, 1'b1, 1'b1, $urandom);
      add_point($urandom, 32'd49152, 1'b1, 1'b0, $urandom);
      add_point($urandom, 32'd65536, 1'b1, 1'b0, $urandom);
      add_point($urandom, 32'd24576, 1'b1, 1'b0, $urandom);
      add_point($urandom, -32'sd5, 1'b1, 1'b0, $urandom);
      add_point($urandom, 32'h7FFFFFFF, 1'b1, 1'b0, $urandom);
      add_point($urandom, 32'd32768, 1'b0, 1'b0, $urandom);
      wait_idle();

      // Frame without intensity falls back to the mode default
      write_reg(CSR_FRAME_HAS_INT, 32'd0);
      add_point($urandom, 32'd32768, 1'b1, 1'b1, $urandom);
      wait_idle();

      // Height with equal bounds, inverted bounds and the widest range
      write_reg(CSR_COLOR_MODE, MODE_HEIGHT);
      write_reg(CSR_HGT_MIN, 32'd1000);
      write_reg(CSR_HGT_MAX, 32'd1000);
      add_point(32'd1000, $urandom, 1'b1, 1'b1, $urandom);
      wait_idle();
      write_reg(CSR_HGT_MIN, 32'd5000);
      write_reg(CSR_HGT_MAX, -32'sd5000);
      add_point(32'd0, $urandom, 1'b0, 1'b0, $urandom);
      wait_idle();
      write_reg(CSR_HGT_MIN, 32'h80000000);
      write_reg(CSR_HGT_MAX, 32'h7FFFFFFF);
      add_point(32'h80000000, $urandom, 1'b0, 1'b0, $urandom);
      add_point(32'h7FFFFFFF, $urandom, 1'b0, 1'b0, $urandom);
      add_point(32'h0, $urandom, 1'b0, 1'b0, $urandom);
      wait_idle();

      // Rgb passthrough, point without color, frame without color
      write_reg(CSR_COLOR_MODE, MODE_RGB);
      write_reg(CSR_FRAME_HAS_RGB, 32'd1);
      add_point($urandom, $urandom, 1'b1, 1'b1, 32'h12345678);
      add_point($urandom, $urandom, 1'b1, 1'b0, 32'h9ABCDEF0);
      wait_idle();
      write_reg(CSR_FRAME_HAS_RGB, 32'd0);
      add_point($urandom, $urandom, 1'b1, 1'b1, 32'h0F1E2D3C);
      wait_idle();

      // Random phases: every register rewritten, then a burst of points
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p >= CALM_PHASE) calm = 1'b1;
         junk = $urandom;
         write_reg(CSR_COLOR_MODE, (junk & ~32'd3) | 32'(p % 4));
         junk = $urandom;
         write_reg(CSR_FRAME_HAS_INT, (junk & ~32'd1) | 32'($urandom_range(0, 3) != 0));
         junk = $urandom;
         write_reg(CSR_FRAME_HAS_RGB, (junk & ~32'd1) | 32'($urandom_range(0, 3) != 0));
         pick_bounds(lo, hi);
         write_reg(CSR_INT_MIN, lo);
         write_reg(CSR_INT_MAX, hi);
         pick_bounds(lo, hi);
         write_reg(CSR_HGT_MIN, lo);
         write_reg(CSR_HGT_MAX, hi);
         for (k = 0; k < PHASE_POINTS; k++) begin
            pt.height    = pick_value(cfg_hgt_min, cfg_hgt_max);
            pt.intensity = pick_value(cfg_int_min, cfg_int_max);
            pt.has_int   = ($urandom_range(0, 4) != 0);
            pt.has_rgb   = ($urandom_range(0, 4) != 0);
            pt.color     = $urandom;
            point_queue.insert(point_queue.size(), pt);
         end
         wait_idle();
      end

      repeat (30) @(posedge clock);
      $display("Covered %0d requests over %0d register writes: flat %0d, intensity %0d,",
               mode_hits[0] + mode_hits[1] + mode_hits[2] + mode_hits[3], settings,
               mode_hits[0], mode_hits[1]);
      $display("height %0d, rgb %0d; %0d results compared.", mode_hits[2], mode_hits[3],
               checked);
      if (errors == 0 && color_expect.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, color_expect.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
design/pcs_pkg.sv
design/pcs_norm.sv
design/pcs_div.sv
design/pcs_grad.sv
design/point_colormap_shader_core.sv
test/testbench.sv
